/* hw/rtl/vwc_pkg.sv */
// Shared types and constants of the 3x3 valid-window convolution block.
package vwc_pkg;

    localparam int KSIZE     = 3;
    localparam int KTAPS     = KSIZE * KSIZE;
    localparam int NUM_CH    = 3;
    localparam int PIX_W     = 8;
    localparam int PPIX_W    = NUM_CH * PIX_W;
    localparam int COEF_W    = 16;
    localparam int PROD_W    = PIX_W + 1 + COEF_W;
    localparam int ROWSUM_W  = PROD_W + 2;
    localparam int SUM_W     = 28;
    localparam int CFG_W     = KSIZE * COEF_W;
    localparam int CFG_IDX_W = 3;
    localparam int FW_W      = 11;
    localparam int FH_W      = 12;
    localparam int ROW_W     = 12;

    localparam logic [FW_W-1:0] RESET_WIDTH  = 11'd640;
    localparam logic [FH_W-1:0] RESET_HEIGHT = 12'd480;

    // Output queue: also bounds the number of items in flight.
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_TOP = 3'd0,
        CFG_COEF_MID = 3'd1,
        CFG_COEF_BOT = 3'd2,
        CFG_WIDTH    = 3'd3,
        CFG_HEIGHT   = 3'd4,
        CFG_MODE     = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_ch0;
        logic [PIX_W-1:0] pixel_ch1;
        logic [PIX_W-1:0] pixel_ch2;
    } pix_in_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum_ch0;
        logic signed [SUM_W-1:0] sum_ch1;
        logic signed [SUM_W-1:0] sum_ch2;
        logic                    frame_end;
    } res_out_t;

    // Packed pixel: ch0 in the low byte.
    typedef logic [PPIX_W-1:0] ppix_t;
    typedef ppix_t [KTAPS-1:0] window_t;
    typedef logic [KTAPS-1:0][PIX_W-1:0] chan_win_t;
    typedef logic [KTAPS-1:0][COEF_W-1:0] kernel_t;
    typedef logic [NUM_CH-1:0][SUM_W-1:0] lane_sums_t;

    typedef struct packed {
        logic produce;
        logic last;
    } item_tag_t;

endpackage

/* hw/rtl/vwc_ram.sv */
// Generic simple dual-port RAM with registered read.
module vwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/vwc_window.sv */
// Raster counters, line stores and the 3x3 window of packed pixels.
module vwc_window
    import vwc_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            restart,
    input  logic            accept,
    input  ppix_t           px,
    input  logic [FW_W-1:0] frame_width,
    input  logic [FH_W-1:0] frame_height,
    output logic            win_valid,
    output window_t         win,
    output item_tag_t       win_tag
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int EXT_W  = 14;

    logic [EXT_W-1:0]  fw_ext;
    logic [EXT_W-1:0]  w_last_ext;
    logic [ADDR_W-1:0] w_last;
    logic [ROW_W-1:0]  h_last;

    logic [ADDR_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    item_tag_t         tag_now;

    logic              s1_valid_reg;
    ppix_t             s1_px_reg;
    logic [ADDR_W-1:0] s1_col_reg;
    item_tag_t         s1_tag_reg;

    logic [2*PPIX_W-1:0] rd_data;
    ppix_t               rd_older;
    ppix_t               rd_newer;

    window_t   win_reg, win_next;
    logic      win_valid_reg;
    item_tag_t win_tag_reg;

    // Clamp the line length to 3..MAX_WIDTH and the frame height to 3 or more.
    assign fw_ext = EXT_W'(frame_width);

    always_comb
    begin
        if (fw_ext < EXT_W'(3))
        begin
            w_last_ext = EXT_W'(2);
        end
        else if (fw_ext > EXT_W'(MAX_WIDTH))
        begin
            w_last_ext = EXT_W'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last_ext = fw_ext - EXT_W'(1);
        end
    end

    assign w_last = w_last_ext[ADDR_W-1:0];
    assign h_last = (frame_height < FH_W'(3)) ? ROW_W'(2) : ROW_W'(frame_height - FH_W'(1));

    assign tag_now.produce = (row_reg >= ROW_W'(2)) && (col_reg >= ADDR_W'(2));
    assign tag_now.last    = (row_reg == h_last) && (col_reg == w_last);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == w_last)
            begin
                col_next = '0;
                row_next = (row_reg == h_last) ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            win_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            s1_valid_reg  <= accept;
            win_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_px_reg   <= px;
        s1_col_reg  <= col_reg;
        s1_tag_reg  <= tag_now;
        win_tag_reg <= s1_tag_reg;
        if (s1_valid_reg)
        begin
            win_reg <= win_next;
        end
    end

    // Each entry holds {newer line, older line}; read now, rewritten in the cycle after.
    vwc_ram #(
        .WIDTH (2 * PPIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data ({s1_px_reg, rd_newer}),
        .rd_addr (col_reg),
        .rd_data (rd_data)
    );

    assign rd_older = rd_data[PPIX_W-1:0];
    assign rd_newer = rd_data[2*PPIX_W-1:PPIX_W];

    // Shift every row left and load the new column: older, newer, incoming.
    always_comb
    begin
        win_next = win_reg;
        for (int r = 0; r < KSIZE; r++)
        begin
            for (int c = 0; c < KSIZE - 1; c++)
            begin
                win_next[r*KSIZE+c] = win_reg[r*KSIZE+c+1];
            end
        end
        win_next[KSIZE-1]   = rd_older;
        win_next[2*KSIZE-1] = rd_newer;
        win_next[KTAPS-1]   = s1_px_reg;
    end

    assign win_valid = win_valid_reg;
    assign win       = win_reg;
    assign win_tag   = win_tag_reg;

endmodule

/* hw/rtl/vwc_lane.sv */
// One channel lane: nine products, three row sums, one window sum.
module vwc_lane
    import vwc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  item_tag_t               in_tag,
    input  chan_win_t               pix,
    input  kernel_t                 kernel,
    output logic                    out_valid,
    output item_tag_t               out_tag,
    output logic signed [SUM_W-1:0] sum
);

    logic signed [PROD_W-1:0]   prod_reg [KTAPS];
    logic signed [PROD_W-1:0]   prod_next [KTAPS];
    logic signed [ROWSUM_W-1:0] row_reg [KSIZE];
    logic signed [ROWSUM_W-1:0] row_next [KSIZE];
    logic signed [SUM_W-1:0]    sum_reg;

    logic [2:0]  valid_pipe_reg;
    item_tag_t   tag_p_reg;
    item_tag_t   tag_r_reg;
    item_tag_t   tag_s_reg;

    always_comb
    begin
        for (int k = 0; k < KTAPS; k++)
        begin
            prod_next[k] = PROD_W'($signed({1'b0, pix[k]}) * $signed(kernel[k]));
        end
    end

    always_comb
    begin
        for (int r = 0; r < KSIZE; r++)
        begin
            row_next[r] = ROWSUM_W'(prod_reg[r*KSIZE])
                        + ROWSUM_W'(prod_reg[r*KSIZE+1])
                        + ROWSUM_W'(prod_reg[r*KSIZE+2]);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        row_reg   <= row_next;
        sum_reg   <= SUM_W'(row_reg[0]) + SUM_W'(row_reg[1]) + SUM_W'(row_reg[2]);
        tag_p_reg <= in_tag;
        tag_r_reg <= tag_p_reg;
        tag_s_reg <= tag_r_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_pipe_reg <= '0;
        end
        else
        begin
            valid_pipe_reg <= {valid_pipe_reg[1:0], in_valid};
        end
    end

    assign out_valid = valid_pipe_reg[2];
    assign out_tag   = tag_s_reg;
    assign sum       = sum_reg;

endmodule

/* hw/rtl/vwc_merge.sv */
// Merge the lane sums into result items, queue them and meter the input.
module vwc_merge
    import vwc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_accept,
    input  logic       lane_valid,
    input  item_tag_t  lane_tag,
    input  lane_sums_t lane_sums,
    output logic       in_stall,
    output logic       res_valid,
    input  logic       res_stall,
    output res_out_t   res
);

    res_out_t         fifo_reg [FIFO_DEPTH];
    res_out_t         merged;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] pending_reg, pending_next;
    logic             push;
    logic             drop;
    logic             pop;

    assign merged.sum_ch0   = lane_sums[0];
    assign merged.sum_ch1   = lane_sums[1];
    assign merged.sum_ch2   = lane_sums[2];
    assign merged.frame_end = lane_tag.last;

    assign push = lane_valid && lane_tag.produce;
    assign drop = lane_valid && !lane_tag.produce;
    assign pop  = res_valid && !res_stall;

    // Pending counts every item from acceptance until its result leaves or is dropped.
    assign pending_next = pending_reg + CNT_W'(in_accept) - CNT_W'(drop) - CNT_W'(pop);
    assign fill_next    = fill_reg + CNT_W'(push) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            fill_reg    <= '0;
            pending_reg <= '0;
        end
        else
        begin
            fill_reg    <= fill_next;
            pending_reg <= pending_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= merged;
        end
    end

    assign in_stall  = (pending_reg == CNT_W'(FIFO_DEPTH));
    assign res_valid = (fill_reg != '0);
    assign res       = fifo_reg[rd_ptr_reg];

endmodule

/* hw/rtl/valid_window_convolution_2d.sv */
// 3x3 valid-window correlation over a raster pixel stream, one or three channels.
//
// The block takes one pixel item per clock and keeps that rate as long as
// results are taken: three identical lanes (one per channel) each form nine
// products, three row sums and one window sum in a registered pipeline, and a
// merge stage packs the lane sums with the frame_end flag into an 8-entry
// output queue. res_valid rises once the result has passed the s1, window,
// product, row-sum and window-sum registers and entered the queue. pix_stall
// rises when 8 items are between acceptance and delivery; with res_stall low
// at most 6 are, so the input never stalls. Only windows that lie fully
// inside the frame give a result: (width-2) x (height-2) items per frame, and
// frame_end marks the last. The two previous lines sit in one RAM of MAX_WIDTH
// entries, 48 bits wide ({newer, older}), read at the accepted column and
// rewritten in the cycle after. No clearing pass runs after reset: every line
// store entry that feeds a result is written earlier in the same frame.
// Coefficients are three signed Q4.11 values per row register, column 0 (the
// oldest pixel) in the low 16 bits. Writing width, height or mode restarts
// the frame; write configuration only while no item is in flight.
module valid_window_convolution_2d
    import vwc_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 pix_valid,
    output logic                 pix_stall,
    input  pix_in_t              pix,
    output logic                 res_valid,
    input  logic                 res_stall,
    output res_out_t             res
);

    logic [CFG_W-1:0] coef_reg [KSIZE];
    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    logic             mode_reg;

    logic       restart;
    logic       accept;
    ppix_t      px;
    kernel_t    kernel;

    logic       win_valid;
    window_t    win;
    item_tag_t  win_tag;

    logic       lane_valid [NUM_CH];
    item_tag_t  lane_tag [NUM_CH];
    lane_sums_t lane_sums;

    // Configuration registers; geometry and mode writes restart the frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < KSIZE; r++)
            begin
                coef_reg[r] <= '0;
            end
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
            mode_reg   <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_COEF_TOP: coef_reg[0] <= cfg_data;
                CFG_COEF_MID: coef_reg[1] <= cfg_data;
                CFG_COEF_BOT: coef_reg[2] <= cfg_data;
                CFG_WIDTH:    width_reg   <= cfg_data[FW_W-1:0];
                CFG_HEIGHT:   height_reg  <= cfg_data[FH_W-1:0];
                CFG_MODE:     mode_reg    <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    assign restart = cfg_wr_en && ((cfg_index == CFG_WIDTH) || (cfg_index == CFG_HEIGHT)
                                || (cfg_index == CFG_MODE));
    assign accept  = pix_valid && !pix_stall;

    // Drop channels one and two in single-channel mode; their sums then come out zero.
    assign px = {mode_reg ? pix.pixel_ch2 : '0, mode_reg ? pix.pixel_ch1 : '0, pix.pixel_ch0};

    always_comb
    begin
        for (int r = 0; r < KSIZE; r++)
        begin
            for (int c = 0; c < KSIZE; c++)
            begin
                kernel[r*KSIZE+c] = coef_reg[r][c*COEF_W +: COEF_W];
            end
        end
    end

    vwc_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .restart      (restart),
        .accept       (accept),
        .px           (px),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .win_valid    (win_valid),
        .win          (win),
        .win_tag      (win_tag)
    );

    for (genvar ch = 0; ch < NUM_CH; ch++)
    begin : g_lane
        chan_win_t chan_win;

        always_comb
        begin
            for (int k = 0; k < KTAPS; k++)
            begin
                chan_win[k] = win[k][ch*PIX_W +: PIX_W];
            end
        end

        vwc_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (win_valid),
            .in_tag    (win_tag),
            .pix       (chan_win),
            .kernel    (kernel),
            .out_valid (lane_valid[ch]),
            .out_tag   (lane_tag[ch]),
            .sum       (lane_sums[ch])
        );
    end

    // All lanes run in lockstep; lane zero carries the control for the merge.
    vwc_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_accept  (accept),
        .lane_valid (lane_valid[0]),
        .lane_tag   (lane_tag[0]),
        .lane_sums  (lane_sums),
        .in_stall   (pix_stall),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

endmodule

/* hw/rtl/vwc_checker.sv */
// Port-level checks of the convolution block, bound to its top level.
module vwc_checker
    import vwc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cfg_wr_en,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [CFG_W-1:0]     cfg_data,
    input logic                 pix_valid,
    input logic                 pix_stall,
    input pix_in_t              pix,
    input logic                 res_valid,
    input logic                 res_stall,
    input res_out_t             res
);

    logic mode_shadow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_shadow_reg <= 1'b0;
        end
        else if (cfg_wr_en && (cfg_index == CFG_MODE))
        begin
            mode_shadow_reg <= cfg_data[0];
        end
    end

    // A stalled result item holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result item changed while stalled");

    // A stalled pixel item holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_stall |=> pix_valid && $stable(pix))
        else $error("pixel item changed while stalled");

    // Input back-pressure only builds up right after an item was taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pix_stall) |-> $past(pix_valid && !pix_stall))
        else $error("input stall rose without a preceding accept");

    // Single-channel mode leaves channels one and two at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !mode_shadow_reg |-> (res.sum_ch1 == '0) && (res.sum_ch2 == '0))
        else $error("nonzero upper channel sum in single-channel mode");

endmodule

bind valid_window_convolution_2d vwc_checker u_vwc_checker (.*);
